FILE: design/edge_length_subdivider_macros.svh
// Assertion macros for the edge length subdivider.
// Used by the top level; expects clk and arst_n in scope.
`ifndef EDGE_LENGTH_SUBDIVIDER_MACROS_SVH
`define EDGE_LENGTH_SUBDIVIDER_MACROS_SVH

// same-cycle implication
`define ELS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("els assertion failed");

// next-cycle implication
`define ELS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("els assertion failed");

`endif

FILE: design/els_pkg.sv
// Shared types and constants for the edge length subdivider.
// No dependencies.
`timescale 1ns / 1ps
package els_pkg;
	localparam int UW   = 38;
	localparam int NS_W = 7;

	typedef enum logic {
		REG_SPACING   = 1'b0,
		REG_FIRST_AUX = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [UW-1:0] diff;
		logic          ge;
	} sub_res_t;
endpackage

FILE: design/els_sub.sv
// Shared subtract/compare unit: one restoring step of sqrt or division.
// Depends on els_pkg.
`timescale 1ns / 1ps
module els_sub (
	input  logic [els_pkg::UW-1:0] x,
	input  logic [els_pkg::UW-1:0] y,
	output els_pkg::sub_res_t      res
);
	import els_pkg::*;

	assign res.diff = x - y;
	assign res.ge   = (x >= y);
endmodule

FILE: design/edge_length_subdivider.sv
// Top level of the edge length subdivider: sequencer, datapath registers.
// Depends on els_pkg, els_sub and edge_length_subdivider_macros.svh.
//
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | a_x a_y a_z b_x b_y b_z
// out     | output    | out_valid / out_ready | point_x/y/z, index, count, too_many, last
// cfg     | input     | cfg_we                | cfg_idx, cfg_wdata
//
// One edge: capture, squaring of the differences, integer root, length divide,
// then setup and per point a step and, per axis, a load and a divide, plus the
// output hand-off. All root and divide steps use the single els_sub unit.
// in_ready is high only while idle. Results wait in registers under out_ready.
// Reset is asynchronous, active low; no clearing pass.
`timescale 1ns / 1ps
`include "edge_length_subdivider_macros.svh"
module edge_length_subdivider #(
	parameter int MAX_POINTS_PER_EDGE = 32,
	parameter int INDEX_BITS          = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [31:0]           a_x,
	input  logic signed [31:0]           a_y,
	input  logic signed [31:0]           a_z,
	input  logic signed [31:0]           b_x,
	input  logic signed [31:0]           b_y,
	input  logic signed [31:0]           b_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [31:0]           point_x,
	output logic signed [31:0]           point_y,
	output logic signed [31:0]           point_z,
	output logic [INDEX_BITS-1:0]        point_index,
	output logic [5:0]                   point_count,
	output logic                         too_many,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic [31:0]                  cfg_wdata
);
	import els_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SQR  = 8'b0000_0010,
		S_ROOT = 8'b0000_0100,
		S_DIV  = 8'b0000_1000,
		S_INIT = 8'b0001_0000,
		S_STEP = 8'b0010_0000,
		S_LOAD = 8'b0100_0000,
		S_PDIV = 8'b1000_0000
	} st_t;

	localparam logic [5:0] ROOT_LAST = 6'd33;
	localparam logic [5:0] DIV_LAST  = 6'd33;
	localparam logic [5:0] PDIV_LAST = 6'(UW - 1);

	st_t                    state_q;
	logic                   out_q;
	logic                   err_q;
	logic signed [31:0]     a_q [3];
	logic signed [31:0]     b_q [3];
	logic signed [38:0]     num_q [3];
	logic signed [31:0]     px_q [3];
	logic [67:0]            acc_q;
	logic [UW-1:0]          rem_q;
	logic [UW-1:0]          quo_q;
	logic [5:0]             cnt_q;
	logic [1:0]             k_q;
	logic [5:0]             j_q;
	logic [NS_W-1:0]        ns_q;
	logic                   neg_q;
	logic [31:0]            spacing_q;
	logic [INDEX_BITS-1:0]  first_aux_q;
	logic [INDEX_BITS-1:0]  next_off_q;
	logic [INDEX_BITS-1:0]  idx_q;

	logic signed [32:0]     dk;
	logic [32:0]            mag33;
	logic [65:0]            sq;
	logic signed [39:0]     nsa;
	logic [31:0]            sp;
	logic [UW-1:0]          ux;
	logic [UW-1:0]          uy;
	sub_res_t               ures;
	logic [UW-1:0]          qnext;
	logic [UW-1:0]          remnext;
	logic [38:0]            nmag;
	logic [5:0]             npts;
	logic                   in_acc;
	logic                   out_acc;
	logic                   is_last;

	assign in_ready = (state_q == S_IDLE) && !out_q;
	assign out_valid = out_q;
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_q && out_ready;
	assign npts = 6'(ns_q - NS_W'(1));
	assign is_last = err_q || (j_q == npts);

	assign point_x = px_q[0];
	assign point_y = px_q[1];
	assign point_z = px_q[2];
	assign point_index = idx_q;
	assign point_count = err_q ? 6'd0 : npts;
	assign too_many = err_q;
	assign last = is_last;

	assign dk = 33'(a_q[k_q]) - 33'(b_q[k_q]);
	assign mag33 = dk[32] ? 33'(-dk) : 33'(dk);
	assign sq = 66'(mag33) * 66'(mag33);
	assign nsa = a_q[k_q] * $signed({1'b0, ns_q});
	assign sp = (spacing_q == 32'd0) ? 32'd1 : spacing_q;
	assign nmag = num_q[k_q][38] ? 39'(-num_q[k_q]) : 39'(num_q[k_q]);

	always_comb begin
		if (state_q == S_ROOT) begin
			ux = {rem_q[UW-3:0], acc_q[67:66]};
			uy = UW'({quo_q[33:0], 2'b01});
		end else begin
			ux = {rem_q[UW-2:0], acc_q[67]};
			uy = (state_q == S_DIV) ? UW'(sp) : UW'(ns_q);
		end
	end

	els_sub u_sub (
		.x   (ux),
		.y   (uy),
		.res (ures)
	);

	assign qnext = {quo_q[UW-2:0], ures.ge};
	assign remnext = ures.ge ? ures.diff : ux;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= 32'd65536;
			first_aux_q <= '0;
			next_off_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_SPACING) begin
					spacing_q <= cfg_wdata;
				end else begin
					first_aux_q <= INDEX_BITS'(cfg_wdata[23:0]);
					next_off_q <= '0;
				end
			end else if (out_acc && !err_q) begin
				next_off_q <= next_off_q + INDEX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_q <= 1'b0;
			err_q <= 1'b0;
			cnt_q <= '0;
			k_q <= '0;
			j_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (out_acc) begin
						out_q <= 1'b0;
						if (!is_last) begin
							state_q <= S_STEP;
						end
					end else if (in_acc) begin
						a_q[0] <= a_x;
						a_q[1] <= a_y;
						a_q[2] <= a_z;
						b_q[0] <= b_x;
						b_q[1] <= b_y;
						b_q[2] <= b_z;
						acc_q <= '0;
						k_q <= '0;
						err_q <= 1'b0;
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					acc_q <= acc_q + 68'(sq);
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						cnt_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					rem_q <= remnext;
					quo_q <= qnext;
					acc_q <= {acc_q[65:0], 2'b00};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == ROOT_LAST) begin
						acc_q <= {qnext[33:0], 34'd0};
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= remnext;
					quo_q <= qnext;
					acc_q <= {acc_q[66:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						if (qnext[33:0] <= 34'd1) begin
							state_q <= S_IDLE;
						end else if (qnext[33:0] > 34'(MAX_POINTS_PER_EDGE + 1)) begin
							err_q <= 1'b1;
							px_q[0] <= '0;
							px_q[1] <= '0;
							px_q[2] <= '0;
							idx_q <= '0;
							out_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							ns_q <= qnext[NS_W-1:0];
							k_q <= '0;
							j_q <= '0;
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					num_q[k_q] <= 39'(nsa);
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					for (int i = 0; i < 3; i++) begin
						num_q[i] <= num_q[i] + 39'(33'(b_q[i]) - 33'(a_q[i]));
					end
					j_q <= j_q + 6'd1;
					k_q <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					acc_q <= {nmag[UW-1:0] + UW'(ns_q >> 1), 30'd0};
					neg_q <= num_q[k_q][38];
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
					state_q <= S_PDIV;
				end
				S_PDIV: begin
					rem_q <= remnext;
					quo_q <= qnext;
					acc_q <= {acc_q[66:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == PDIV_LAST) begin
						px_q[k_q] <= neg_q ? -qnext[31:0] : qnext[31:0];
						k_q <= k_q + 2'd1;
						if (k_q == 2'd2) begin
							idx_q <= first_aux_q + next_off_q;
							out_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ELS_ASSERT_NOW(a_out_blocks_in, out_valid, !in_ready)
	`ELS_ASSERT_NOW(a_err_is_last, out_valid && too_many, last && (point_count == 6'd0))
	`ELS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == S_SQR)
	`ELS_ASSERT_NEXT(a_more_points, out_valid && out_ready && !last, state_q == S_STEP)
endmodule
